[hw/rtl/ppcm_pkg.sv]
// Shared constants and types for the periodic pair cutoff mapper.
// Holds the register map, fixed field widths and reset values.
// No dependencies.
package ppcm_pkg;

   localparam int MARGIN         = 28;
   localparam int ROUND_SHIFT    = 28;
   localparam int BOX_BITS       = 24;
   localparam int CUT_BITS       = 48;
   localparam int SCALE_BITS     = 24;
   localparam int IMG_BITS       = 13;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOX_WIDTH      = 3'd0,
      CSR_BOX_HEIGHT     = 3'd1,
      CSR_CUTOFF_SQUARED = 3'd2,
      CSR_SCALE_X        = 3'd3,
      CSR_SCALE_Y        = 3'd4,
      CSR_IMAGE_HEIGHT   = 3'd5
   } csr_index_type;

   localparam logic [BOX_BITS-1:0]   BOX_WIDTH_RESET      = 24'd409600;
   localparam logic [BOX_BITS-1:0]   BOX_HEIGHT_RESET     = 24'd409600;
   localparam logic [CUT_BITS-1:0]   CUTOFF_SQUARED_RESET = 48'd63795610;
   localparam logic [SCALE_BITS-1:0] SCALE_X_RESET        = 24'd65536;
   localparam logic [SCALE_BITS-1:0] SCALE_Y_RESET        = 24'd65536;
   localparam logic [IMG_BITS-1:0]   IMAGE_HEIGHT_RESET   = 13'd512;

endpackage

[hw/rtl/ppcm_pixel_map.sv]
// Three-stage coordinate to pixel mapper: multiply, round half up, offset and saturate.
// Optional y flip against the image height.
// Depends on ppcm_pkg.
module ppcm_pixel_map #(
   parameter int IN_BITS    = 25,
   parameter int PIXEL_BITS = 12,
   parameter bit FLIP       = 1'b0
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [IN_BITS-1:0]               coord,
   input  logic [ppcm_pkg::SCALE_BITS-1:0]  scale,
   input  logic [ppcm_pkg::IMG_BITS-1:0]    image_height,
   output logic [PIXEL_BITS-1:0]            pixel
);
   import ppcm_pkg::*;

   localparam int PW = IN_BITS + SCALE_BITS;
   localparam int RW = PW + 1 - ROUND_SHIFT;
   localparam int VW = ((RW > IMG_BITS) ? RW : IMG_BITS) + 2;
   localparam logic signed [VW-1:0] MARGIN_S  = VW'(MARGIN);
   localparam logic signed [VW-1:0] PIX_MAX_S = VW'((1 << PIXEL_BITS) - 1);
   localparam logic [PW:0]          HALF      = (PW+1)'(1) << (ROUND_SHIFT - 1);

   logic [PW-1:0]         prod_ff;
   logic [PW:0]           sum_in;
   logic [RW-1:0]         round_ff;
   logic signed [VW-1:0]  ih_s;
   logic signed [VW-1:0]  r_s;
   logic signed [VW-1:0]  val_in;
   logic [PIXEL_BITS-1:0] pixel_in;
   logic [PIXEL_BITS-1:0] pixel_ff;

   assign sum_in = {1'b0, prod_ff} + HALF;
   assign ih_s   = $signed({{(VW-IMG_BITS){1'b0}}, image_height});
   assign r_s    = $signed({{(VW-RW){1'b0}}, round_ff});

   always_comb begin
      if (FLIP) begin
         val_in = ih_s - MARGIN_S - r_s;
      end else begin
         val_in = MARGIN_S + r_s;
      end
      if (val_in < 0) begin
         pixel_in = '0;
      end else if (val_in > PIX_MAX_S) begin
         pixel_in = '1;
      end else begin
         pixel_in = val_in[PIXEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= PW'(coord) * PW'(scale);
         round_ff <= sum_in[PW:ROUND_SHIFT];
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

[hw/rtl/periodic_pair_cutoff_mapper.sv]
// Periodic pair cutoff mapper, top level.
// Seven-stage pipeline of wrap, distance, in-box test and pixel mapping.
// Depends on ppcm_pkg and ppcm_pixel_map.
//
// One request enters per cycle while the output is not stalled, so the sustained
// rate is one pair per clock; the pipeline runs through the delta subtraction,
// the two wrap steps and the partner point, followed by the three-stage pixel
// mappers for the partner; the squaring and cutoff compare run beside those
// mappers. All stages advance together whenever the output register is empty
// or its response is taken, so a stalled output holds the whole pipeline in
// place. Configuration writes are taken in any cycle and are read at several
// stages; rewrite them only while the pipeline is empty.
module periodic_pair_cutoff_mapper #(
   parameter int COORD_BITS = 24,
   parameter int PIXEL_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_first_x,
   input  logic [COORD_BITS-1:0]               req_first_y,
   input  logic                                req_first_on_boundary,
   input  logic [COORD_BITS-1:0]               req_second_x,
   input  logic [COORD_BITS-1:0]               req_second_y,
   input  logic                                req_second_on_boundary,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_connect,
   output logic [PIXEL_BITS-1:0]               rsp_start_px,
   output logic [PIXEL_BITS-1:0]               rsp_start_py,
   output logic [PIXEL_BITS-1:0]               rsp_end_px,
   output logic [PIXEL_BITS-1:0]               rsp_end_py,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppcm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ppcm_pkg::*;

   localparam int EW = (COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS;
   localparam int DW = EW + 3;
   localparam int AW = EW;
   localparam int MW = EW + 1;
   localparam int SW = 2 * AW + 1;

   logic [BOX_BITS-1:0]   box_width_ff;
   logic [BOX_BITS-1:0]   box_height_ff;
   logic [CUT_BITS-1:0]   cutoff_ff;
   logic [SCALE_BITS-1:0] scale_x_ff;
   logic [SCALE_BITS-1:0] scale_y_ff;
   logic [IMG_BITS-1:0]   image_height_ff;

   logic       advance;
   logic [7:1] valid_ff;

   logic [COORD_BITS-1:0] x0_ff [1:3];
   logic [COORD_BITS-1:0] y0_ff [1:3];
   logic [5:1]            pair_ff;

   logic signed [DW-1:0] box_x;
   logic signed [DW-1:0] box_y;
   logic signed [DW-1:0] dx1_ff, dy1_ff;
   logic signed [DW-1:0] dx2_in, dy2_in, dx2_ff, dy2_ff;
   logic signed [DW-1:0] dx3_in, dy3_in, dx3_ff, dy3_ff;
   logic [AW-1:0]        ax4_in, ay4_in, ax4_ff, ay4_ff;
   logic signed [DW-1:0] xj4_in, yj4_in, xj4_ff, yj4_ff;
   logic [2*AW-1:0]      sqx5_ff, sqy5_ff;
   logic                 in5_in, in5_ff;
   logic [SW-1:0]        dist6_in;
   logic                 conn6_in, conn6_ff, conn7_ff;

   logic [PIXEL_BITS-1:0] spx3, spy3, epx7, epy7;
   logic [PIXEL_BITS-1:0] spx_ff [4:7];
   logic [PIXEL_BITS-1:0] spy_ff [4:7];

   assign advance   = !valid_ff[7] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff    <= BOX_WIDTH_RESET;
         box_height_ff   <= BOX_HEIGHT_RESET;
         cutoff_ff       <= CUTOFF_SQUARED_RESET;
         scale_x_ff      <= SCALE_X_RESET;
         scale_y_ff      <= SCALE_Y_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_WIDTH:      box_width_ff    <= csr_data[BOX_BITS-1:0];
            CSR_BOX_HEIGHT:     box_height_ff   <= csr_data[BOX_BITS-1:0];
            CSR_CUTOFF_SQUARED: cutoff_ff       <= csr_data[CUT_BITS-1:0];
            CSR_SCALE_X:        scale_x_ff      <= csr_data[SCALE_BITS-1:0];
            CSR_SCALE_Y:        scale_y_ff      <= csr_data[SCALE_BITS-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff <= csr_data[IMG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[6:1], req_valid};
      end
   end

   assign box_x = $signed({{(DW-BOX_BITS){1'b0}}, box_width_ff});
   assign box_y = $signed({{(DW-BOX_BITS){1'b0}}, box_height_ff});

   // one wrap per axis: pull down past half box, then push up past minus half box
   assign dx2_in = ((dx1_ff <<< 1) > box_x) ? dx1_ff - box_x : dx1_ff;
   assign dy2_in = ((dy1_ff <<< 1) > box_y) ? dy1_ff - box_y : dy1_ff;
   assign dx3_in = ((dx2_ff <<< 1) < -box_x) ? dx2_ff + box_x : dx2_ff;
   assign dy3_in = ((dy2_ff <<< 1) < -box_y) ? dy2_ff + box_y : dy2_ff;

   assign ax4_in = dx3_ff[DW-1] ? AW'(-dx3_ff) : AW'(dx3_ff);
   assign ay4_in = dy3_ff[DW-1] ? AW'(-dy3_ff) : AW'(dy3_ff);
   assign xj4_in = $signed({{(DW-COORD_BITS){1'b0}}, x0_ff[3]}) + dx3_ff;
   assign yj4_in = $signed({{(DW-COORD_BITS){1'b0}}, y0_ff[3]}) + dy3_ff;

   assign in5_in = !xj4_ff[DW-1] && (xj4_ff < box_x) &&
                   !yj4_ff[DW-1] && (yj4_ff < box_y);

   assign dist6_in = {1'b0, sqx5_ff} + {1'b0, sqy5_ff};
   assign conn6_in = pair_ff[5] && in5_ff &&
                     (dist6_in <= {{(SW-CUT_BITS){1'b0}}, cutoff_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         dx1_ff   <= $signed({{(DW-COORD_BITS){1'b0}}, req_second_x}) -
                     $signed({{(DW-COORD_BITS){1'b0}}, req_first_x});
         dy1_ff   <= $signed({{(DW-COORD_BITS){1'b0}}, req_second_y}) -
                     $signed({{(DW-COORD_BITS){1'b0}}, req_first_y});
         x0_ff[1] <= req_first_x;
         y0_ff[1] <= req_first_y;
         x0_ff[2] <= x0_ff[1];
         y0_ff[2] <= y0_ff[1];
         x0_ff[3] <= x0_ff[2];
         y0_ff[3] <= y0_ff[2];
         pair_ff  <= {pair_ff[4:1], req_first_on_boundary & req_second_on_boundary};
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         dx3_ff   <= dx3_in;
         dy3_ff   <= dy3_in;
         ax4_ff   <= ax4_in;
         ay4_ff   <= ay4_in;
         xj4_ff   <= xj4_in;
         yj4_ff   <= yj4_in;
         sqx5_ff  <= ax4_ff * ax4_ff;
         sqy5_ff  <= ay4_ff * ay4_ff;
         in5_ff   <= in5_in;
         conn6_ff <= conn6_in;
         conn7_ff <= conn6_ff;
         spx_ff[4] <= spx3;
         spy_ff[4] <= spy3;
         spx_ff[5] <= spx_ff[4];
         spy_ff[5] <= spy_ff[4];
         spx_ff[6] <= spx_ff[5];
         spy_ff[6] <= spy_ff[5];
         spx_ff[7] <= spx_ff[6];
         spy_ff[7] <= spy_ff[6];
      end
   end

   ppcm_pixel_map #(.IN_BITS(MW), .PIXEL_BITS(PIXEL_BITS), .FLIP(1'b0)) u_start_x (
      .clock        (clock),
      .en           (advance),
      .coord        (MW'(req_first_x)),
      .scale        (scale_x_ff),
      .image_height (image_height_ff),
      .pixel        (spx3)
   );

   ppcm_pixel_map #(.IN_BITS(MW), .PIXEL_BITS(PIXEL_BITS), .FLIP(1'b1)) u_start_y (
      .clock        (clock),
      .en           (advance),
      .coord        (MW'(req_first_y)),
      .scale        (scale_y_ff),
      .image_height (image_height_ff),
      .pixel        (spy3)
   );

   ppcm_pixel_map #(.IN_BITS(MW), .PIXEL_BITS(PIXEL_BITS), .FLIP(1'b0)) u_end_x (
      .clock        (clock),
      .en           (advance),
      .coord        (xj4_ff[MW-1:0]),
      .scale        (scale_x_ff),
      .image_height (image_height_ff),
      .pixel        (epx7)
   );

   ppcm_pixel_map #(.IN_BITS(MW), .PIXEL_BITS(PIXEL_BITS), .FLIP(1'b1)) u_end_y (
      .clock        (clock),
      .en           (advance),
      .coord        (yj4_ff[MW-1:0]),
      .scale        (scale_y_ff),
      .image_height (image_height_ff),
      .pixel        (epy7)
   );

   assign rsp_valid    = valid_ff[7];
   assign rsp_connect  = conn7_ff;
   assign rsp_start_px = spx_ff[7];
   assign rsp_start_py = spy_ff[7];
   assign rsp_end_px   = conn7_ff ? epx7 : '0;
   assign rsp_end_py   = conn7_ff ? epy7 : '0;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[1])
      else $error("accepted request did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (valid_ff == $past(valid_ff)))
      else $error("pipeline valids moved during a stall");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while the output is stalled");

   a_no_conn_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_connect) |-> (rsp_end_px == '0 && rsp_end_py == '0))
      else $error("end pixel nonzero without a connection");

endmodule
